@@ rtl/cpp_pkg.sv @@
// ---------------------------------------------------------------------------
// Camera point projection package
// Shared field widths, register indexes, status codes and the configuration
// bundle passed between the pipeline sections.
// ---------------------------------------------------------------------------
package cpp_pkg;

	// Fixed field formats of the configuration registers.
	localparam int ROT_W       = 18;  // signed Q2.16 rotation entry
	localparam int TRN_W       = 21;  // signed translation, 12 fraction bits
	localparam int FOC_W       = 20;  // unsigned intrinsic, 8 fraction bits
	localparam int ROW_REG_W   = 3 * ROT_W;
	localparam int TRN_REG_W   = 3 * TRN_W;
	localparam int INTR_REG_W  = 2 * FOC_W;
	localparam int CFG_DATA_W  = TRN_REG_W;
	localparam int CFG_IDX_W   = 3;

	// Scaling shifts of the fixed-point path.
	localparam int TRN_SHIFT   = 16;  // translation up to the 2^28 scale
	localparam int DEPTH_SHIFT = 9;   // 2^28 scale down to 2^19
	localparam int HALF_SHIFT  = 7;   // half of the divisor, Z * 128
	localparam int DEN_SHIFT   = 8;   // divisor, Z * 256

	localparam int STATUS_W    = 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ROT_X     = 3'd0,
		REG_ROT_Y     = 3'd1,
		REG_ROT_Z     = 3'd2,
		REG_TRANS     = 3'd3,
		REG_FOCAL     = 3'd4,
		REG_PRINCIPAL = 3'd5,
		REG_IMG_SIZE  = 3'd6
	} reg_idx_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_HIT     = 2'd0,
		ST_BEHIND  = 2'd1,
		ST_OUTSIDE = 2'd2
	} status_t;

	// Reset values give the identity rotation.
	localparam logic [ROW_REG_W-1:0] ROT_X_RST = 54'd65536;
	localparam logic [ROW_REG_W-1:0] ROT_Y_RST = 54'd17179869184;
	localparam logic [ROW_REG_W-1:0] ROT_Z_RST = 54'd4503599627370496;

	// Geometry configuration shared by the transform and projection sections.
	typedef struct packed {
		logic [ROW_REG_W-1:0]  rot_x;
		logic [ROW_REG_W-1:0]  rot_y;
		logic [ROW_REG_W-1:0]  rot_z;
		logic [TRN_REG_W-1:0]  trans;
		logic [INTR_REG_W-1:0] focal;
		logic [INTR_REG_W-1:0] principal;
	} geom_cfg_t;

endpackage

@@ rtl/camera_point_projection.sv @@
// ---------------------------------------------------------------------------
// Camera point projection
// Moves a 3D point into the camera frame and projects it onto the image.
// ---------------------------------------------------------------------------
// The slave stream carries one point per transfer: x, y and z, signed with
// 12 fraction bits. The master stream returns one result per point: a status
// (hit, behind camera, outside image) and the rounded pixel column and row,
// which are zero unless the point hits the image.
// Registers are written through cfg_we, cfg_index and cfg_data while no
// point is in flight; writes to unknown indexes are dropped.
// The pipeline has PIXEL_BITS + 7 stages (19 at the default): six for the
// transform, intrinsic products and numerators, one per quotient bit of the
// pipelined dividers, and the output register. A point enters the first stage
// at the edge that takes it, and a new point is taken every cycle while the
// master side accepts results.
// Every stage holds a valid bit and loads whenever it is empty or its
// successor loads, so a stalled master side fills the empty stages first and
// only then drops s_tready. Nothing is lost or repeated during a stall.
// Reset clears all valid bits and loads the identity rotation, with all
// other configuration registers zero.
// ---------------------------------------------------------------------------
module camera_point_projection #(
	parameter int COORD_BITS = 24,
	parameter int PIXEL_BITS = 12
) (
	input  logic clk,
	input  logic arst_n,

	input  logic s_tvalid,
	output logic s_tready,
	// point_x, point_y, point_z
	input  logic [((3*COORD_BITS+7)/8)*8-1:0] s_tdata,

	output logic m_tvalid,
	input  logic m_tready,
	// status, pixel_col, pixel_row
	output logic [((2+2*PIXEL_BITS+7)/8)*8-1:0] m_tdata,

	input  logic                           cfg_we,
	input  logic [cpp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [cpp_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam int OUT_W = ((2+2*PIXEL_BITS+7)/8)*8;
	localparam int XW    = COORD_BITS + 22 - cpp_pkg::DEPTH_SHIFT;
	localparam int NW    = XW + 22;
	localparam int DW    = XW + cpp_pkg::DEN_SHIFT;
	localparam int DIV0  = 6;
	localparam int NS    = DIV0 + PIXEL_BITS + 1;
	localparam int IMG_W = 2 * PIXEL_BITS;

	cpp_pkg::geom_cfg_t cfg_q;
	logic [IMG_W-1:0]   img_q;

	logic [NS-1:0] vld_q;
	logic [NS:0]   en;

	logic signed [XW-1:0] cam_x, cam_y, cam_z;
	logic [NW-1:0] num_col, num_row;
	logic          neg_col, neg_row, behind;
	logic [DW-1:0] den;
	logic [PIXEL_BITS-1:0] qc, qr;
	logic          nc, nr, oc, orow;
	logic          beh_s [PIXEL_BITS];
	logic          col_bad, row_bad;
	cpp_pkg::status_t status_s;
	logic [PIXEL_BITS-1:0] col_s, row_s;
	logic [PIXEL_BITS-1:0] cols, rows;

	// Configuration register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rot_x     <= cpp_pkg::ROT_X_RST;
			cfg_q.rot_y     <= cpp_pkg::ROT_Y_RST;
			cfg_q.rot_z     <= cpp_pkg::ROT_Z_RST;
			cfg_q.trans     <= '0;
			cfg_q.focal     <= '0;
			cfg_q.principal <= '0;
			img_q           <= '0;
		end else if (cfg_we) begin
			unique case (cpp_pkg::reg_idx_t'(cfg_index))
				cpp_pkg::REG_ROT_X:     cfg_q.rot_x <= cfg_data[cpp_pkg::ROW_REG_W-1:0];
				cpp_pkg::REG_ROT_Y:     cfg_q.rot_y <= cfg_data[cpp_pkg::ROW_REG_W-1:0];
				cpp_pkg::REG_ROT_Z:     cfg_q.rot_z <= cfg_data[cpp_pkg::ROW_REG_W-1:0];
				cpp_pkg::REG_TRANS:     cfg_q.trans <= cfg_data[cpp_pkg::TRN_REG_W-1:0];
				cpp_pkg::REG_FOCAL:     cfg_q.focal <= cfg_data[cpp_pkg::INTR_REG_W-1:0];
				cpp_pkg::REG_PRINCIPAL: cfg_q.principal <= cfg_data[cpp_pkg::INTR_REG_W-1:0];
				cpp_pkg::REG_IMG_SIZE:  img_q <= cfg_data[IMG_W-1:0];
				default: ;
			endcase
		end
	end

	assign cols = img_q[PIXEL_BITS-1:0];
	assign rows = img_q[IMG_W-1:PIXEL_BITS];

	// Stage load enables, from the output side back to the input.
	always_comb begin
		en[NS] = m_tready;
		for (int i = NS - 1; i >= 0; i--) begin
			en[i] = !vld_q[i] || en[i+1];
		end
	end

	assign s_tready = en[0];
	assign m_tvalid = vld_q[NS-1];

	// Valid bits travel with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			for (int i = 0; i < NS; i++) begin
				if (en[i]) begin
					vld_q[i] <= (i == 0) ? s_tvalid : vld_q[i-1];
				end
			end
		end
	end

	cpp_transform #(.COORD_BITS(COORD_BITS)) u_transform (
		.clk     (clk),
		.en      (en[1:0]),
		.cfg     (cfg_q),
		.point_x ($signed(s_tdata[0 +: COORD_BITS])),
		.point_y ($signed(s_tdata[COORD_BITS +: COORD_BITS])),
		.point_z ($signed(s_tdata[2*COORD_BITS +: COORD_BITS])),
		.cam_x   (cam_x),
		.cam_y   (cam_y),
		.cam_z   (cam_z)
	);

	cpp_project #(.XW(XW)) u_project (
		.clk     (clk),
		.en      (en[5:2]),
		.cfg     (cfg_q),
		.cam_x   (cam_x),
		.cam_y   (cam_y),
		.cam_z   (cam_z),
		.num_col (num_col),
		.num_row (num_row),
		.neg_col (neg_col),
		.neg_row (neg_row),
		.den     (den),
		.behind  (behind)
	);

	cpp_divider #(.NW(NW), .DW(DW), .QW(PIXEL_BITS)) u_div_col (
		.clk     (clk),
		.en      (en[DIV0 +: PIXEL_BITS]),
		.num     (num_col),
		.den     (den),
		.neg     (neg_col),
		.quot    (qc),
		.neg_out (nc),
		.ovf     (oc)
	);

	cpp_divider #(.NW(NW), .DW(DW), .QW(PIXEL_BITS)) u_div_row (
		.clk     (clk),
		.en      (en[DIV0 +: PIXEL_BITS]),
		.num     (num_row),
		.den     (den),
		.neg     (neg_row),
		.quot    (qr),
		.neg_out (nr),
		.ovf     (orow)
	);

	// Depth flag runs alongside the dividers.
	always_ff @(posedge clk) begin
		for (int j = 0; j < PIXEL_BITS; j++) begin
			if (en[DIV0+j]) begin
				beh_s[j] <= (j == 0) ? behind : beh_s[j-1];
			end
		end
	end

	// A negative pixel that rounds to zero is still column or row zero.
	assign col_bad = oc || (nc && (qc != '0)) || (qc >= cols);
	assign row_bad = orow || (nr && (qr != '0)) || (qr >= rows);

	// Output register: status and pixel, zeroed unless the point hits.
	always_ff @(posedge clk) begin
		if (en[NS-1]) begin
			if (beh_s[PIXEL_BITS-1]) begin
				status_s <= cpp_pkg::ST_BEHIND;
				col_s    <= '0;
				row_s    <= '0;
			end else if (col_bad || row_bad) begin
				status_s <= cpp_pkg::ST_OUTSIDE;
				col_s    <= '0;
				row_s    <= '0;
			end else begin
				status_s <= cpp_pkg::ST_HIT;
				col_s    <= qc;
				row_s    <= qr;
			end
		end
	end

	assign m_tdata = OUT_W'({row_s, col_s, status_s});

	// A blocked input means every stage is holding an item.
	assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (&vld_q))
		else $error("input blocked while a stage is empty");

	// Results that miss the image carry no pixel.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (status_s != cpp_pkg::ST_HIT) |-> (col_s == '0) && (row_s == '0))
		else $error("pixel set on a miss");

	// A hit lies inside the configured image.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (status_s == cpp_pkg::ST_HIT) |-> (col_s < cols) && (row_s < rows))
		else $error("hit outside image bounds");

	// An output held by the receiver does not change.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result changed");

endmodule

@@ rtl/cpp_transform.sv @@
// ---------------------------------------------------------------------------
// Rigid transform section
// Two stages: nine rotation products, then the row sums plus translation,
// reduced to the 2^19 scale with a floor shift.
// ---------------------------------------------------------------------------
module cpp_transform #(
	parameter int COORD_BITS = 24
) (
	input  logic                                  clk,
	input  logic [1:0]                            en,
	input  cpp_pkg::geom_cfg_t                    cfg,
	input  logic signed [COORD_BITS-1:0]          point_x,
	input  logic signed [COORD_BITS-1:0]          point_y,
	input  logic signed [COORD_BITS-1:0]          point_z,
	output logic signed [COORD_BITS+22-cpp_pkg::DEPTH_SHIFT-1:0] cam_x,
	output logic signed [COORD_BITS+22-cpp_pkg::DEPTH_SHIFT-1:0] cam_y,
	output logic signed [COORD_BITS+22-cpp_pkg::DEPTH_SHIFT-1:0] cam_z
);

	localparam int PW = COORD_BITS + cpp_pkg::ROT_W;
	localparam int AW = COORD_BITS + 22;

	logic signed [PW-1:0] prod_s1 [3][3];
	logic signed [cpp_pkg::ROW_REG_W-1:0] rows [3];
	logic signed [COORD_BITS-1:0] pt [3];
	logic signed [AW-1:0] acc [3];
	logic signed [cpp_pkg::TRN_W-1:0] trn [3];

	assign rows[0] = cfg.rot_x;
	assign rows[1] = cfg.rot_y;
	assign rows[2] = cfg.rot_z;
	assign pt[0]   = point_x;
	assign pt[1]   = point_y;
	assign pt[2]   = point_z;

	// Stage 1: one product per rotation entry.
	always_ff @(posedge clk) begin
		if (en[0]) begin
			for (int r = 0; r < 3; r++) begin
				for (int k = 0; k < 3; k++) begin
					prod_s1[r][k] <= PW'($signed(rows[r][k*cpp_pkg::ROT_W +: cpp_pkg::ROT_W]))
						* PW'(pt[k]);
				end
			end
		end
	end

	// Stage 2 sums, with the translation lifted to the product scale.
	always_comb begin
		for (int r = 0; r < 3; r++) begin
			trn[r] = $signed(cfg.trans[r*cpp_pkg::TRN_W +: cpp_pkg::TRN_W]);
			acc[r] = AW'(prod_s1[r][0]) + AW'(prod_s1[r][1]) + AW'(prod_s1[r][2])
				+ (AW'(trn[r]) <<< cpp_pkg::TRN_SHIFT);
		end
	end

	// Stage 2: dropping the low bits of a two's complement value is a floor shift.
	always_ff @(posedge clk) begin
		if (en[1]) begin
			cam_x <= $signed(acc[0][AW-1:cpp_pkg::DEPTH_SHIFT]);
			cam_y <= $signed(acc[1][AW-1:cpp_pkg::DEPTH_SHIFT]);
			cam_z <= $signed(acc[2][AW-1:cpp_pkg::DEPTH_SHIFT]);
		end
	end

endmodule

@@ rtl/cpp_project.sv @@
// ---------------------------------------------------------------------------
// Projection numerator section
// Four stages: intrinsic products, numerators, magnitudes, and the rounding
// offset added ahead of the divider. Also forms the divisor and depth flag.
// ---------------------------------------------------------------------------
module cpp_project #(
	parameter int XW = 37
) (
	input  logic                     clk,
	input  logic [3:0]               en,
	input  cpp_pkg::geom_cfg_t       cfg,
	input  logic signed [XW-1:0]     cam_x,
	input  logic signed [XW-1:0]     cam_y,
	input  logic signed [XW-1:0]     cam_z,
	output logic [XW+21:0]           num_col,
	output logic [XW+21:0]           num_row,
	output logic                     neg_col,
	output logic                     neg_row,
	output logic [XW+cpp_pkg::DEN_SHIFT-1:0] den,
	output logic                     behind
);

	localparam int MW = XW + cpp_pkg::FOC_W + 1;
	localparam int NW = XW + 22;
	localparam int FS = cpp_pkg::FOC_W + 1;

	logic signed [FS-1:0] fx, fy, cx, cy;
	logic signed [MW-1:0] mfx_s3, mcx_s3, mfy_s3, mcy_s3;
	logic signed [XW-1:0] z_s3, z_s4, z_s5;
	logic                 beh_s3, beh_s4, beh_s5;
	logic signed [NW-1:0] nc_s4, nr_s4;
	logic [NW-1:0]        ac_s5, ar_s5;
	logic                 nc_s5, nr_s5;

	assign fx = $signed({1'b0, cfg.focal[0 +: cpp_pkg::FOC_W]});
	assign fy = $signed({1'b0, cfg.focal[cpp_pkg::FOC_W +: cpp_pkg::FOC_W]});
	assign cx = $signed({1'b0, cfg.principal[0 +: cpp_pkg::FOC_W]});
	assign cy = $signed({1'b0, cfg.principal[cpp_pkg::FOC_W +: cpp_pkg::FOC_W]});

	// Stage 3: intrinsic products and the depth test.
	always_ff @(posedge clk) begin
		if (en[0]) begin
			mfx_s3 <= MW'(fx) * MW'(cam_x);
			mcx_s3 <= MW'(cx) * MW'(cam_z);
			mfy_s3 <= MW'(fy) * MW'(cam_y);
			mcy_s3 <= MW'(cy) * MW'(cam_z);
			z_s3   <= cam_z;
			beh_s3 <= cam_z[XW-1] || (cam_z == '0);
		end
	end

	// Stage 4: signed numerators.
	always_ff @(posedge clk) begin
		if (en[1]) begin
			nc_s4  <= NW'(mfx_s3) + NW'(mcx_s3);
			nr_s4  <= NW'(mfy_s3) + NW'(mcy_s3);
			z_s4   <= z_s3;
			beh_s4 <= beh_s3;
		end
	end

	// Stage 5: magnitudes, the sign sets the direction of rounding.
	always_ff @(posedge clk) begin
		if (en[2]) begin
			nc_s5  <= nc_s4[NW-1];
			nr_s5  <= nr_s4[NW-1];
			ac_s5  <= nc_s4[NW-1] ? NW'(-nc_s4) : NW'(nc_s4);
			ar_s5  <= nr_s4[NW-1] ? NW'(-nr_s4) : NW'(nr_s4);
			z_s5   <= z_s4;
			beh_s5 <= beh_s4;
		end
	end

	// Stage 6: add half the divisor so the floor quotient rounds to nearest.
	always_ff @(posedge clk) begin
		if (en[3]) begin
			num_col <= ac_s5 + (NW'(z_s5) << cpp_pkg::HALF_SHIFT);
			num_row <= ar_s5 + (NW'(z_s5) << cpp_pkg::HALF_SHIFT);
			neg_col <= nc_s5;
			neg_row <= nr_s5;
			den     <= (XW + cpp_pkg::DEN_SHIFT)'(z_s5) << cpp_pkg::DEN_SHIFT;
			behind  <= beh_s5;
		end
	end

endmodule

@@ rtl/cpp_divider.sv @@
// ---------------------------------------------------------------------------
// Pipelined restoring divider
// One quotient bit per stage, most significant first. The first stage also
// flags a quotient that does not fit in QW bits.
// ---------------------------------------------------------------------------
module cpp_divider #(
	parameter int NW = 59,
	parameter int DW = 45,
	parameter int QW = 12
) (
	input  logic          clk,
	input  logic [QW-1:0] en,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	input  logic          neg,
	output logic [QW-1:0] quot,
	output logic          neg_out,
	output logic          ovf
);

	localparam int RW = NW + DW + QW + 1;

	logic [NW-1:0] rem_s [QW];
	logic [DW-1:0] den_s [QW];
	logic [QW-1:0] q_s   [QW];
	logic          neg_s [QW];
	logic          ovf_s [QW];

	for (genvar j = 0; j < QW; j++) begin : g_stage
		localparam int K = QW - 1 - j;
		logic [NW-1:0] rem_in;
		logic [DW-1:0] den_in;
		logic [QW-1:0] q_in;
		logic          neg_in, ovf_in;
		logic [RW-1:0] trial;
		logic          take;

		if (j == 0) begin : g_first
			assign rem_in = num;
			assign den_in = den;
			assign q_in   = '0;
			assign neg_in = neg;
			assign ovf_in = (RW'(num) >= (RW'(den) << QW));
		end else begin : g_next
			assign rem_in = rem_s[j-1];
			assign den_in = den_s[j-1];
			assign q_in   = q_s[j-1];
			assign neg_in = neg_s[j-1];
			assign ovf_in = ovf_s[j-1];
		end

		// Trial subtraction of the shifted divisor.
		assign trial = RW'(den_in) << K;
		assign take  = (RW'(rem_in) >= trial);

		always_ff @(posedge clk) begin
			if (en[j]) begin
				rem_s[j] <= take ? NW'(RW'(rem_in) - trial) : rem_in;
				den_s[j] <= den_in;
				q_s[j]   <= {q_in[QW-2:0], take};
				neg_s[j] <= neg_in;
				ovf_s[j] <= ovf_in;
			end
		end
	end

	assign quot    = q_s[QW-1];
	assign neg_out = neg_s[QW-1];
	assign ovf     = ovf_s[QW-1];

endmodule

@@ verif/tb_camera_point_projection.sv @@
// ---------------------------------------------------------------------------
// Camera point projection testbench
// Streams 3D points through the block under several camera setups and checks
// each result against a fixed-point prediction of the transform, the pinhole
// projection, the rounding and the status decision. Both stream sides idle
// in random bursts except in the last, quiet phase.
// ---------------------------------------------------------------------------
module tb_camera_point_projection;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int COORD_W = 24;
	localparam int PIX_W   = 12;
	localparam int NREGS   = 7;
	localparam int DATA_W  = cpp_pkg::CFG_DATA_W;
	localparam int ROT_W   = cpp_pkg::ROT_W;
	localparam int TRN_W   = cpp_pkg::TRN_W;

	// One expected projection result.
	typedef struct {
		cpp_pkg::status_t status;
		logic [PIX_W-1:0] col;
		logic [PIX_W-1:0] row;
	} pixel_t;

	// Scoreboard: a copy of the registers, the predictor and the result store.
	class projection_scoreboard;
		logic [DATA_W-1:0] regs [NREGS];
		pixel_t pending [$];
		int mismatches;
		int points;
		int hits;
		int behind;
		int outside;

		function new();
			regs[cpp_pkg::REG_ROT_X] = DATA_W'(cpp_pkg::ROT_X_RST);
			regs[cpp_pkg::REG_ROT_Y] = DATA_W'(cpp_pkg::ROT_Y_RST);
			regs[cpp_pkg::REG_ROT_Z] = DATA_W'(cpp_pkg::ROT_Z_RST);
			for (int i = cpp_pkg::REG_TRANS; i < NREGS; i++) regs[i] = '0;
			mismatches = 0;
			points = 0;
			hits = 0;
			behind = 0;
			outside = 0;
		endfunction

		function void write_reg(int idx, logic [DATA_W-1:0] val);
			if (idx < NREGS) begin
				case (idx)
					cpp_pkg::REG_ROT_X, cpp_pkg::REG_ROT_Y, cpp_pkg::REG_ROT_Z:
						regs[idx] = val & {{9{1'b0}}, {54{1'b1}}};
					cpp_pkg::REG_TRANS: regs[idx] = val;
					cpp_pkg::REG_FOCAL, cpp_pkg::REG_PRINCIPAL:
						regs[idx] = val & {{23{1'b0}}, {40{1'b1}}};
					default: regs[idx] = val & {{39{1'b0}}, {24{1'b1}}};
				endcase
			end
		endfunction

		// Quotient rounded to nearest, halves away from zero; den is positive.
		function longint div_round(longint num, longint den);
			longint mag;
			longint q;
			mag = (num < 0) ? -num : num;
			q = (mag + den / 2) / den;
			return (num < 0) ? -q : q;
		endfunction

		// Predicts the result of one accepted point.
		function void note_point(logic [3*COORD_W-1:0] data);
			longint p [3];
			longint cam [3];
			longint acc;
			longint fx, fy, cx, cy, cols, rows, den, col, row;
			pixel_t e;
			for (int k = 0; k < 3; k++) p[k] = longint'($signed(data[COORD_W*k +: COORD_W]));
			for (int r = 0; r < 3; r++) begin
				acc = 0;
				for (int k = 0; k < 3; k++)
					acc += longint'($signed(regs[r][ROT_W*k +: ROT_W])) * p[k];
				acc += longint'($signed(regs[cpp_pkg::REG_TRANS][TRN_W*r +: TRN_W])) * 65536;
				cam[r] = acc >>> cpp_pkg::DEPTH_SHIFT;
			end
			e.status = cpp_pkg::ST_HIT;
			e.col = '0;
			e.row = '0;
			if (cam[2] <= 0) begin
				e.status = cpp_pkg::ST_BEHIND;
				behind++;
			end else begin
				fx = longint'(regs[cpp_pkg::REG_FOCAL][19:0]);
				fy = longint'(regs[cpp_pkg::REG_FOCAL][39:20]);
				cx = longint'(regs[cpp_pkg::REG_PRINCIPAL][19:0]);
				cy = longint'(regs[cpp_pkg::REG_PRINCIPAL][39:20]);
				cols = longint'(regs[cpp_pkg::REG_IMG_SIZE][11:0]);
				rows = longint'(regs[cpp_pkg::REG_IMG_SIZE][23:12]);
				den = cam[2] * 256;
				col = div_round(fx * cam[0] + cx * cam[2], den);
				row = div_round(fy * cam[1] + cy * cam[2], den);
				if (col < 0 || row < 0 || col >= cols || row >= rows) begin
					e.status = cpp_pkg::ST_OUTSIDE;
					outside++;
				end else begin
					e.col = col[PIX_W-1:0];
					e.row = row[PIX_W-1:0];
					hits++;
				end
			end
			points++;
			pending.insert(pending.size(), e);
		endfunction

		task report_mismatch(string msg);
			$display("MISMATCH at %0t: %s", $realtime, msg);
			mismatches++;
		endtask

		// Compares one result transfer with the oldest prediction.
		task check_result(logic [31:0] data);
			pixel_t e;
			if (pending.size() == 0) begin
				report_mismatch($sformatf("unexpected result 0x%08h", data));
				return;
			end
			e = pending.pop_front();
			if (data[1:0] != e.status)
				report_mismatch($sformatf("status %0d, expected %0d", data[1:0], e.status));
			if (data[13:2] != e.col)
				report_mismatch($sformatf("column %0d, expected %0d", data[13:2], e.col));
			if (data[25:14] != e.row)
				report_mismatch($sformatf("row %0d, expected %0d", data[25:14], e.row));
		endtask
	endclass

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [3*COORD_W-1:0] s_tdata;
	logic m_tvalid;
	logic m_tready;
	logic [31:0] m_tdata;
	logic cfg_we;
	logic [cpp_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [DATA_W-1:0] cfg_data;

	projection_scoreboard sb;
	bit quiet;
	int stall_left;

	camera_point_projection dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// Clock.
	initial clk = 1'b0;
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Run limit.
	initial begin
		#3ms;
		$display("Verification failed");
		$finish;
	end

	// Result side: random stall bursts, none in quiet mode.
	initial begin
		m_tready = 1'b0;
		stall_left = 0;
		forever begin
			@(negedge clk);
			if (quiet) begin
				m_tready = 1'b1;
			end else if (stall_left > 0) begin
				m_tready = 1'b0;
				stall_left--;
			end else if ($urandom_range(0, 6) == 0) begin
				m_tready = 1'b0;
				stall_left = $urandom_range(1, 18) - 1;
			end else begin
				m_tready = 1'b1;
			end
		end
	end

	// Every result transfer is checked.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) sb.check_result(m_tdata);
	end

	// Called at a falling edge; returns at a falling edge after the transfer.
	task automatic send_point(logic signed [COORD_W-1:0] x, logic signed [COORD_W-1:0] y,
			logic signed [COORD_W-1:0] z);
		logic [3*COORD_W-1:0] word;
		word = {z, y, x};
		if (!quiet && $urandom_range(0, 6) == 0) begin
			s_tvalid = 1'b0;
			repeat ($urandom_range(1, 18)) @(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata = word;
		do @(posedge clk); while (!s_tready);
		sb.note_point(word);
		@(negedge clk);
	endtask

	// Lets the pipeline empty before registers change.
	task automatic drain();
		s_tvalid = 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (30) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_reg(int idx, logic [DATA_W-1:0] val);
		cfg_we = 1'b1;
		cfg_index = cpp_pkg::CFG_IDX_W'(idx);
		cfg_data = val;
		sb.write_reg(idx, val);
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	function automatic logic [DATA_W-1:0] pack_rot(int a, int b, int c);
		logic [ROT_W-1:0] ea, eb, ec;
		ea = ROT_W'(a);
		eb = ROT_W'(b);
		ec = ROT_W'(c);
		return DATA_W'({ec, eb, ea});
	endfunction

	function automatic logic [DATA_W-1:0] pack_trans(int a, int b, int c);
		logic [TRN_W-1:0] ea, eb, ec;
		ea = TRN_W'(a);
		eb = TRN_W'(b);
		ec = TRN_W'(c);
		return {ec, eb, ea};
	endfunction

	// A camera with a 640 by 480 image, identity pose.
	task automatic setup_camera();
		write_reg(cpp_pkg::REG_ROT_X, pack_rot(65536, 0, 0));
		write_reg(cpp_pkg::REG_ROT_Y, pack_rot(0, 65536, 0));
		write_reg(cpp_pkg::REG_ROT_Z, pack_rot(0, 0, 65536));
		write_reg(cpp_pkg::REG_TRANS, '0);
		write_reg(cpp_pkg::REG_FOCAL, DATA_W'({20'(500 * 256), 20'(500 * 256)}));
		write_reg(cpp_pkg::REG_PRINCIPAL, DATA_W'({20'(240 * 256), 20'(320 * 256)}));
		write_reg(cpp_pkg::REG_IMG_SIZE, DATA_W'({12'd480, 12'd640}));
	endtask

	// A point in front of the camera, mostly within the view cone.
	task automatic send_view_point();
		int z, x, y;
		z = $urandom_range(200, 30 * 4096);
		x = int'($urandom_range(0, z)) - z / 2;
		y = int'($urandom_range(0, z)) - z / 2;
		send_point(COORD_W'(x), COORD_W'(y), COORD_W'(z));
	endtask

	task automatic send_any_point();
		send_point(COORD_W'($urandom), COORD_W'($urandom), COORD_W'($urandom));
	endtask

	initial begin
		sb = new();
		quiet = 1'b0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset setup: zero image size puts every point outside or behind.
		send_point(24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF);
		send_point(24'sh800000, 24'sh800000, 24'sh800000);
		send_point(0, 0, 0);
		send_point(0, 0, 4096);
		repeat (10) send_any_point();
		drain();

		// Realistic camera; the unknown index must be ignored.
		setup_camera();
		write_reg(7, '1);
		send_point(0, 0, 4096);                 // image center
		send_point(0, 0, 0);                    // zero depth
		send_point(0, 0, -4096);                // behind
		send_point(0, 0, 1);                    // tiny positive depth
		send_point(24'sh7FFFFF, 0, 4096);       // far right
		send_point(-4096, -4096, 4096);         // negative pixel
		send_point(5235, 0, 8192);              // column just above 639.5, rounds outside
		send_point(5227, 3850, 8192);           // just inside the far corner
		send_point(-2622, 0, 4096);             // column near zero
		send_point(24'sh800000, 24'sh800000, 24'sh7FFFFF);
		repeat (200) begin
			if ($urandom_range(0, 3) != 0) send_view_point();
			else send_any_point();
		end
		drain();

		// Perturbed pose, random intrinsics and image size.
		write_reg(cpp_pkg::REG_ROT_X, pack_rot(65536 + $urandom_range(0, 4000) - 2000,
			$urandom_range(0, 4000) - 2000, $urandom_range(0, 4000) - 2000));
		write_reg(cpp_pkg::REG_ROT_Y, pack_rot($urandom_range(0, 4000) - 2000,
			65536 + $urandom_range(0, 4000) - 2000, $urandom_range(0, 4000) - 2000));
		write_reg(cpp_pkg::REG_ROT_Z, pack_rot($urandom_range(0, 4000) - 2000,
			$urandom_range(0, 4000) - 2000, 65536 + $urandom_range(0, 4000) - 2000));
		write_reg(cpp_pkg::REG_TRANS, pack_trans($urandom_range(0, 8192) - 4096,
			$urandom_range(0, 8192) - 4096, $urandom_range(0, 4096)));
		write_reg(cpp_pkg::REG_FOCAL, DATA_W'({20'($urandom_range(100, 1500) * 256),
			20'($urandom_range(100, 1500) * 256)}));
		write_reg(cpp_pkg::REG_PRINCIPAL, DATA_W'({20'($urandom_range(0, 1 << 20)),
			20'($urandom_range(0, 1 << 20))}));
		write_reg(cpp_pkg::REG_IMG_SIZE, DATA_W'({12'($urandom_range(1, 4095)),
			12'($urandom_range(1, 4095))}));
		repeat (150) begin
			if ($urandom_range(0, 3) != 0) send_view_point();
			else send_any_point();
		end
		drain();

		// Every register at its largest value.
		for (int i = cpp_pkg::REG_ROT_X; i < NREGS; i++) write_reg(i, '1);
		repeat (60) send_any_point();
		drain();

		// Every register zero.
		for (int i = cpp_pkg::REG_ROT_X; i < NREGS; i++) write_reg(i, '0);
		send_point(24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF);
		repeat (30) send_any_point();
		drain();

		// Back to the realistic camera with both sides running freely.
		setup_camera();
		quiet = 1'b1;
		repeat (150) begin
			if ($urandom_range(0, 3) != 0) send_view_point();
			else send_any_point();
		end
		drain();

		$display("Projected %0d points: %0d hits, %0d behind camera, %0d outside image.",
			sb.points, sb.hits, sb.behind, sb.outside);
		$display("Mismatches: %0d", sb.mismatches);
		if (sb.mismatches == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
